@@ rtl/jsu_pkg.sv @@
// Shared types and constants for the JSON string unescape block.
package jsu_pkg;

  localparam int unsigned QueueDepth = 4;

  localparam int unsigned MaxBytes = 4;
  localparam int unsigned IdxW = $clog2(MaxBytes);

  typedef struct packed {
    logic [MaxBytes-1:0][7:0] bytes;
    logic [IdxW-1:0]          last_idx;
    logic                     byte_valid;
    logic                     string_done;
    logic [3:0]               error_code;
  } jsu_job_t;

endpackage

@@ rtl/json_string_unescape_utf8.sv @@
// Top level of the JSON string body to UTF-8 decoder.
//
//   Channel  Direction  Contents
//   in_*     input      tdata: data_byte[7:0]; tuser: end_of_text
//   out_*    output     tdata: out_byte[7:0]; tuser: byte_valid, string_done,
//                       error_code[3:0]; tlast: last
//
// The input takes one byte per cycle while the job queue has room.
// Each byte yields zero to four results, sent one per cycle by the serializer
// while the output is ready, so a code point of n UTF-8 bytes gives n results.
// A result passes from its byte through the job queue and then the output register.
// Synchronous active-low reset returns the decoder to plain character mode.
// Either side may stall; the queue absorbs the difference.
module json_string_unescape_utf8 #(
  parameter int unsigned QueueDepth = jsu_pkg::QueueDepth
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // data_byte[7:0]
  input  logic       in_tuser,   // end_of_text
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // out_byte[7:0]
  output logic [5:0] out_tuser,  // byte_valid, string_done, error_code[3:0]
  output logic       out_tlast
);

  logic              push;
  logic              q_ready;
  logic              pop;
  logic              head_valid;
  jsu_pkg::jsu_job_t push_job;
  jsu_pkg::jsu_job_t head_job;

  jsu_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_tvalid),
    .in_ready    (in_tready),
    .data_byte   (in_tdata),
    .end_of_text (in_tuser),
    .q_ready     (q_ready),
    .push        (push),
    .job         (push_job)
  );

  jsu_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_job   (push_job),
    .not_full   (q_ready),
    .pop        (pop),
    .head_valid (head_valid),
    .head_job   (head_job)
  );

  jsu_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (head_valid),
    .head_job   (head_job),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule

@@ rtl/jsu_front.sv @@
// Front end: accepts string bytes, tracks escape state and builds output jobs.
module jsu_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [7:0]         data_byte,
  input  logic               end_of_text,
  input  logic               q_ready,
  output logic               push,
  output jsu_pkg::jsu_job_t  job
);

  typedef enum logic [5:0] {
    MODE_PLAIN   = 6'b000001,
    MODE_ESC     = 6'b000010,
    MODE_HEX1    = 6'b000100,
    MODE_HEX2    = 6'b001000,
    MODE_NEED_BS = 6'b010000,
    MODE_NEED_U  = 6'b100000
  } mode_t;

  localparam logic [3:0] ERR_NONE       = 4'd0;
  localparam logic [3:0] ERR_UNTERM_STR = 4'd1;
  localparam logic [3:0] ERR_CTRL_CHAR  = 4'd2;
  localparam logic [3:0] ERR_UNTERM_ESC = 4'd3;
  localparam logic [3:0] ERR_BAD_ESC    = 4'd4;
  localparam logic [3:0] ERR_UNTERM_HEX = 4'd5;
  localparam logic [3:0] ERR_BAD_HEX    = 4'd6;
  localparam logic [3:0] ERR_UNPAIR_HI  = 4'd7;
  localparam logic [3:0] ERR_BAD_LOW    = 4'd8;
  localparam logic [3:0] ERR_UNPAIR_LO  = 4'd9;

  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5c;
  localparam logic [7:0] CH_SLASH = 8'h2f;
  localparam logic [7:0] CH_U = 8'h75;

  function automatic logic [4:0] hex_digit(input logic [7:0] c);
    logic [4:0] d;
    if (c >= 8'h30 && c <= 8'h39) begin
      d = 5'(c - 8'h30);
    end else if (c >= 8'h61 && c <= 8'h66) begin
      d = 5'(c - 8'h57);
    end else if (c >= 8'h41 && c <= 8'h46) begin
      d = 5'(c - 8'h37);
    end else begin
      d = 5'd16;
    end
    return d;
  endfunction

  function automatic jsu_pkg::jsu_job_t status_job(input logic done, input logic [3:0] err);
    jsu_pkg::jsu_job_t j;
    j = '0;
    j.string_done = done;
    j.error_code = err;
    return j;
  endfunction

  function automatic jsu_pkg::jsu_job_t byte_job(input logic [7:0] b);
    jsu_pkg::jsu_job_t j;
    j = '0;
    j.byte_valid = 1'b1;
    j.bytes[0] = b;
    return j;
  endfunction

  function automatic jsu_pkg::jsu_job_t utf8_job(input logic [20:0] cp);
    jsu_pkg::jsu_job_t j;
    j = '0;
    j.byte_valid = 1'b1;
    if (cp < 21'h80) begin
      j.bytes[0] = {1'b0, cp[6:0]};
      j.last_idx = jsu_pkg::IdxW'(0);
    end else if (cp < 21'h800) begin
      j.bytes[0] = {3'b110, cp[10:6]};
      j.bytes[1] = {2'b10, cp[5:0]};
      j.last_idx = jsu_pkg::IdxW'(1);
    end else if (cp < 21'h10000) begin
      j.bytes[0] = {4'b1110, cp[15:12]};
      j.bytes[1] = {2'b10, cp[11:6]};
      j.bytes[2] = {2'b10, cp[5:0]};
      j.last_idx = jsu_pkg::IdxW'(2);
    end else begin
      j.bytes[0] = {5'b11110, cp[20:18]};
      j.bytes[1] = {2'b10, cp[17:12]};
      j.bytes[2] = {2'b10, cp[11:6]};
      j.bytes[3] = {2'b10, cp[5:0]};
      j.last_idx = jsu_pkg::IdxW'(3);
    end
    return j;
  endfunction

  mode_t       mode_r, mode_nxt;
  logic [11:0] hex_r, hex_nxt;
  logic [1:0]  cnt_r, cnt_nxt;
  logic [9:0]  high_r, high_nxt;
  logic        accept;
  logic        emit;
  logic        clear;
  logic [4:0]  digit;
  logic [15:0] hex_full;
  logic [20:0] pair_cp;
  jsu_pkg::jsu_job_t job_d;

  assign in_ready = q_ready;
  assign accept = in_valid && q_ready;
  assign digit = hex_digit(data_byte);
  assign hex_full = {hex_r, digit[3:0]};
  assign pair_cp = 21'h10000 + 21'({high_r, hex_full[9:0]});

  always_comb begin
    mode_nxt = mode_r;
    hex_nxt = hex_r;
    cnt_nxt = cnt_r;
    high_nxt = high_r;
    emit = 1'b0;
    clear = 1'b0;
    job_d = '0;
    unique case (mode_r)
      MODE_ESC: begin
        mode_nxt = MODE_PLAIN;
        emit = 1'b1;
        if (end_of_text) begin
          clear = 1'b1;
          job_d = status_job(1'b0, ERR_UNTERM_ESC);
        end else begin
          case (data_byte)
            CH_QUOTE:  job_d = byte_job(CH_QUOTE);
            CH_BSLASH: job_d = byte_job(CH_BSLASH);
            CH_SLASH:  job_d = byte_job(CH_SLASH);
            8'h62:     job_d = byte_job(8'h08);
            8'h66:     job_d = byte_job(8'h0c);
            8'h6e:     job_d = byte_job(8'h0a);
            8'h72:     job_d = byte_job(8'h0d);
            8'h74:     job_d = byte_job(8'h09);
            CH_U: begin
              emit = 1'b0;
              mode_nxt = MODE_HEX1;
              hex_nxt = '0;
              cnt_nxt = '0;
            end
            default: begin
              clear = 1'b1;
              job_d = status_job(1'b0, ERR_BAD_ESC);
            end
          endcase
        end
      end
      MODE_HEX1, MODE_HEX2: begin
        if (end_of_text) begin
          emit = 1'b1;
          clear = 1'b1;
          job_d = status_job(1'b0, ERR_UNTERM_HEX);
        end else if (digit[4]) begin
          emit = 1'b1;
          clear = 1'b1;
          job_d = status_job(1'b0, ERR_BAD_HEX);
        end else if (cnt_r != 2'd3) begin
          hex_nxt = hex_full[11:0];
          cnt_nxt = cnt_r + 2'd1;
        end else begin
          hex_nxt = '0;
          cnt_nxt = '0;
          if (mode_r == MODE_HEX1) begin
            if (hex_full[15:10] == 6'b110110) begin
              high_nxt = hex_full[9:0];
              mode_nxt = MODE_NEED_BS;
            end else if (hex_full[15:10] == 6'b110111) begin
              emit = 1'b1;
              clear = 1'b1;
              job_d = status_job(1'b0, ERR_UNPAIR_LO);
            end else begin
              emit = 1'b1;
              mode_nxt = MODE_PLAIN;
              job_d = utf8_job(21'(hex_full));
            end
          end else begin
            emit = 1'b1;
            clear = 1'b1;
            if (hex_full[15:10] != 6'b110111) begin
              job_d = status_job(1'b0, ERR_BAD_LOW);
            end else begin
              job_d = utf8_job(pair_cp);
            end
          end
        end
      end
      MODE_NEED_BS: begin
        if (end_of_text || data_byte != CH_BSLASH) begin
          emit = 1'b1;
          clear = 1'b1;
          job_d = status_job(1'b0, ERR_UNPAIR_HI);
        end else begin
          mode_nxt = MODE_NEED_U;
        end
      end
      MODE_NEED_U: begin
        if (end_of_text || data_byte != CH_U) begin
          emit = 1'b1;
          clear = 1'b1;
          job_d = status_job(1'b0, ERR_UNPAIR_HI);
        end else begin
          mode_nxt = MODE_HEX2;
          hex_nxt = '0;
          cnt_nxt = '0;
        end
      end
      default: begin
        mode_nxt = MODE_PLAIN;
        emit = 1'b1;
        if (end_of_text) begin
          clear = 1'b1;
          job_d = status_job(1'b0, ERR_UNTERM_STR);
        end else if (data_byte == CH_QUOTE) begin
          clear = 1'b1;
          job_d = status_job(1'b1, ERR_NONE);
        end else if (data_byte < 8'h20) begin
          clear = 1'b1;
          job_d = status_job(1'b0, ERR_CTRL_CHAR);
        end else if (data_byte == CH_BSLASH) begin
          emit = 1'b0;
          mode_nxt = MODE_ESC;
        end else begin
          job_d = byte_job(data_byte);
        end
      end
    endcase
    if (clear) begin
      mode_nxt = MODE_PLAIN;
      hex_nxt = '0;
      cnt_nxt = '0;
      high_nxt = '0;
    end
  end

  assign push = accept && emit;
  assign job = job_d;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_PLAIN;
      hex_r <= '0;
      cnt_r <= '0;
      high_r <= '0;
    end else if (accept) begin
      mode_r <= mode_nxt;
      hex_r <= hex_nxt;
      cnt_r <= cnt_nxt;
      high_r <= high_nxt;
    end
  end

endmodule

@@ rtl/jsu_queue.sv @@
// Short job queue between the front end and the byte serializer.
module jsu_queue #(
  parameter int unsigned Depth = jsu_pkg::QueueDepth
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  jsu_pkg::jsu_job_t  push_job,
  output logic               not_full,
  input  logic               pop,
  output logic               head_valid,
  output jsu_pkg::jsu_job_t  head_job
);

  localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CW = $clog2(Depth + 1);

  jsu_pkg::jsu_job_t mem_r [Depth];
  logic [AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          do_push;
  logic          do_pop;

  assign not_full = (cnt_r != CW'(Depth));
  assign head_valid = (cnt_r != '0);
  assign head_job = mem_r[rd_ptr_r];
  assign do_push = push && not_full;
  assign do_pop = pop && head_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(Depth - 1)) ? '0 : wr_ptr_r + AW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(Depth - 1)) ? '0 : rd_ptr_r + AW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + CW'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

endmodule

@@ rtl/jsu_back.sv @@
// Back end: serializes each job into results through an output register.
module jsu_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               head_valid,
  input  jsu_pkg::jsu_job_t  head_job,
  output logic               pop,
  output logic               out_tvalid,
  input  logic               out_tready,
  output logic [7:0]         out_tdata,
  output logic [5:0]         out_tuser,
  output logic               out_tlast
);

  logic [jsu_pkg::IdxW-1:0] idx_r, idx_nxt;
  logic       valid_r;
  logic [7:0] byte_r;
  logic [5:0] user_r;
  logic       last_r;
  logic       load;
  logic       at_last;

  assign load = head_valid && (!valid_r || out_tready);
  assign at_last = (idx_r == head_job.last_idx);
  assign pop = load && at_last;

  always_comb begin
    idx_nxt = idx_r;
    if (load) begin
      idx_nxt = at_last ? '0 : idx_r + jsu_pkg::IdxW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      idx_r <= '0;
    end else begin
      idx_r <= idx_nxt;
      if (load) begin
        valid_r <= 1'b1;
      end else if (out_tready) begin
        valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      byte_r <= head_job.bytes[idx_r];
      user_r <= {head_job.error_code, head_job.string_done, head_job.byte_valid};
      last_r <= at_last;
    end
  end

  assign out_tvalid = valid_r;
  assign out_tdata = byte_r;
  assign out_tuser = user_r;
  assign out_tlast = last_r;

endmodule

@@ sim/utf8_decode_checker.sv @@
`timescale 1ns / 100ps
// Scoreboard that predicts the decoder's UTF-8 results and checks every result transfer.
module utf8_decode_checker (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  input  logic       in_tready,
  input  logic [7:0] in_tdata,   // data_byte[7:0]
  input  logic       in_tuser,   // end_of_text
  input  logic       out_tvalid,
  input  logic       out_tready,
  input  logic [7:0] out_tdata,  // out_byte[7:0]
  input  logic [5:0] out_tuser,  // byte_valid, string_done, error_code[3:0]
  input  logic       out_tlast,
  output int         outstanding,
  output int         mismatches
);

  typedef enum logic [3:0] {
    DM_TEXT,
    DM_ESCAPE,
    DM_HEX_FIRST,
    DM_WANT_BSLASH,
    DM_WANT_U,
    DM_HEX_SECOND
  } decode_mode_t;

  typedef enum logic [3:0] {
    ERR_NONE        = 4'd0,
    ERR_OPEN_STRING = 4'd1,
    ERR_CTRL_CHAR   = 4'd2,
    ERR_OPEN_ESCAPE = 4'd3,
    ERR_BAD_ESCAPE  = 4'd4,
    ERR_OPEN_HEX    = 4'd5,
    ERR_BAD_HEX     = 4'd6,
    ERR_LONE_HIGH   = 4'd7,
    ERR_BAD_LOW     = 4'd8,
    ERR_LONE_LOW    = 4'd9
  } decode_err_t;

  typedef struct packed {
    logic [7:0] data;
    logic       valid;
    logic       done;
    logic [3:0] err;
    logic       last;
  } dec_result_t;

  decode_mode_t mode      = DM_TEXT;
  logic [15:0]  hex_acc   = '0;
  logic [1:0]   digit_cnt = '0;
  logic [9:0]   high_bits = '0;
  dec_result_t  step_results[$];
  dec_result_t  pending_results[$];
  int           err_count = 0;

  function automatic logic [4:0] nibble_of(logic [7:0] c);
    if (c >= "0" && c <= "9") return 5'(c - "0");
    if (c >= "a" && c <= "f") return 5'(c - "a" + 10);
    if (c >= "A" && c <= "F") return 5'(c - "A" + 10);
    return 5'd16;
  endfunction

  task automatic put_result(logic [7:0] b, logic v, logic d, decode_err_t e);
    step_results.insert(step_results.size(),
                        dec_result_t'{data: b, valid: v, done: d, err: e, last: 1'b0});
  endtask

  task automatic clear_state();
    mode      = DM_TEXT;
    hex_acc   = '0;
    digit_cnt = '0;
    high_bits = '0;
  endtask

  task automatic abort_with(decode_err_t e);
    clear_state();
    put_result(8'h00, 1'b0, 1'b0, e);
  endtask

  task automatic put_code_point(logic [20:0] cp);
    if (cp < 21'h80) begin
      put_result(cp[7:0], 1'b1, 1'b0, ERR_NONE);
    end else if (cp < 21'h800) begin
      put_result({3'b110, cp[10:6]}, 1'b1, 1'b0, ERR_NONE);
      put_result({2'b10, cp[5:0]}, 1'b1, 1'b0, ERR_NONE);
    end else if (cp < 21'h10000) begin
      put_result({4'b1110, cp[15:12]}, 1'b1, 1'b0, ERR_NONE);
      put_result({2'b10, cp[11:6]}, 1'b1, 1'b0, ERR_NONE);
      put_result({2'b10, cp[5:0]}, 1'b1, 1'b0, ERR_NONE);
    end else begin
      put_result({5'b11110, cp[20:18]}, 1'b1, 1'b0, ERR_NONE);
      put_result({2'b10, cp[17:12]}, 1'b1, 1'b0, ERR_NONE);
      put_result({2'b10, cp[11:6]}, 1'b1, 1'b0, ERR_NONE);
      put_result({2'b10, cp[5:0]}, 1'b1, 1'b0, ERR_NONE);
    end
  endtask

  task automatic decode_byte(logic [7:0] c, logic eot);
    logic [4:0]  nib;
    logic [15:0] v;
    step_results.delete();
    nib = nibble_of(c);
    case (mode)
      DM_ESCAPE: begin
        if (eot) begin
          abort_with(ERR_OPEN_ESCAPE);
        end else begin
          mode = DM_TEXT;
          case (c)
            "\"", "\\", "/": put_result(c, 1'b1, 1'b0, ERR_NONE);
            "b": put_result(8'h08, 1'b1, 1'b0, ERR_NONE);
            "f": put_result(8'h0c, 1'b1, 1'b0, ERR_NONE);
            "n": put_result(8'h0a, 1'b1, 1'b0, ERR_NONE);
            "r": put_result(8'h0d, 1'b1, 1'b0, ERR_NONE);
            "t": put_result(8'h09, 1'b1, 1'b0, ERR_NONE);
            "u": begin
              mode      = DM_HEX_FIRST;
              hex_acc   = '0;
              digit_cnt = '0;
            end
            default: abort_with(ERR_BAD_ESCAPE);
          endcase
        end
      end
      DM_HEX_FIRST, DM_HEX_SECOND: begin
        if (eot) begin
          abort_with(ERR_OPEN_HEX);
        end else if (nib[4]) begin
          abort_with(ERR_BAD_HEX);
        end else begin
          hex_acc = {hex_acc[11:0], nib[3:0]};
          if (digit_cnt != 2'd3) begin
            digit_cnt = digit_cnt + 2'd1;
          end else begin
            v         = hex_acc;
            hex_acc   = '0;
            digit_cnt = '0;
            if (mode == DM_HEX_FIRST) begin
              if (v >= 16'hd800 && v <= 16'hdbff) begin
                high_bits = v[9:0];
                mode      = DM_WANT_BSLASH;
              end else if (v >= 16'hdc00 && v <= 16'hdfff) begin
                abort_with(ERR_LONE_LOW);
              end else begin
                mode = DM_TEXT;
                put_code_point({5'd0, v});
              end
            end else if (v < 16'hdc00 || v > 16'hdfff) begin
              abort_with(ERR_BAD_LOW);
            end else begin
              put_code_point(21'h10000 + {1'b0, high_bits, v[9:0]});
              clear_state();
            end
          end
        end
      end
      DM_WANT_BSLASH: begin
        if (eot || c != "\\") abort_with(ERR_LONE_HIGH);
        else mode = DM_WANT_U;
      end
      DM_WANT_U: begin
        if (eot || c != "u") begin
          abort_with(ERR_LONE_HIGH);
        end else begin
          mode      = DM_HEX_SECOND;
          hex_acc   = '0;
          digit_cnt = '0;
        end
      end
      default: begin
        mode = DM_TEXT;
        if (eot) begin
          abort_with(ERR_OPEN_STRING);
        end else if (c == "\"") begin
          clear_state();
          put_result(8'h00, 1'b0, 1'b1, ERR_NONE);
        end else if (c < 8'h20) begin
          abort_with(ERR_CTRL_CHAR);
        end else if (c == "\\") begin
          mode = DM_ESCAPE;
        end else begin
          put_result(c, 1'b1, 1'b0, ERR_NONE);
        end
      end
    endcase
    if (step_results.size() > 0) step_results[step_results.size() - 1].last = 1'b1;
    foreach (step_results[i]) pending_results.insert(pending_results.size(), step_results[i]);
  endtask

  always @(posedge clk) begin
    dec_result_t want;
    if (!rst_n) begin
      clear_state();
      pending_results.delete();
    end else begin
      if (in_tvalid && in_tready) decode_byte(in_tdata, in_tuser);
      if (out_tvalid && out_tready) begin
        if (pending_results.size() == 0) begin
          $error("result transfer with nothing expected: out_byte %02h, out_tuser %02h",
                 out_tdata, out_tuser);
          err_count++;
        end else begin
          want = pending_results.pop_front();
          if (out_tdata !== want.data) begin
            $error("out_byte: expected %02h, actual %02h", want.data, out_tdata);
            err_count++;
          end
          if (out_tuser[0] !== want.valid) begin
            $error("byte_valid: expected %0d, actual %0d", want.valid, out_tuser[0]);
            err_count++;
          end
          if (out_tuser[1] !== want.done) begin
            $error("string_done: expected %0d, actual %0d", want.done, out_tuser[1]);
            err_count++;
          end
          if (out_tuser[5:2] !== want.err) begin
            $error("error_code: expected %0d, actual %0d", want.err, out_tuser[5:2]);
            err_count++;
          end
          if (out_tlast !== want.last) begin
            $error("last: expected %0d, actual %0d", want.last, out_tlast);
            err_count++;
          end
        end
      end
    end
    outstanding <= pending_results.size();
    mismatches  <= err_count;
  end

endmodule

@@ sim/tb.sv @@
`timescale 1ns / 100ps
// Testbench top for the JSON string decoder: stimulus, flow control and the verdict.
module tb;

  localparam int QuietLimit = 2000;
  localparam int EndWait    = 20;
  localparam int TotalItems = 210;

  typedef struct packed {
    logic [7:0] data;
    logic       eot;
  } text_item_t;

  logic       clk        = 1'b0;
  logic       rst_n      = 1'b0;
  logic       in_tvalid  = 1'b0;
  logic       in_tready;
  logic [7:0] in_tdata   = '0;
  logic       in_tuser   = 1'b0;
  logic       out_tvalid;
  logic       out_tready = 1'b0;
  logic [7:0] out_tdata;
  logic [5:0] out_tuser;
  logic       out_tlast;
  int         outstanding;
  int         mismatches;
  int         idle_pct     = 0;
  int         stall_pct    = 0;
  int         quiet_cycles = 0;
  text_item_t text_q[$];

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  json_string_unescape_utf8 dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  utf8_decode_checker decode_check (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .out_tlast   (out_tlast),
    .outstanding (outstanding),
    .mismatches  (mismatches)
  );

  always @(negedge clk) begin
    out_tready <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QuietLimit) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic push_byte(logic [7:0] b);
    text_q.insert(text_q.size(), text_item_t'{data: b, eot: 1'b0});
  endtask

  task automatic push_eot();
    text_q.insert(text_q.size(), text_item_t'{data: 8'($urandom_range(255)), eot: 1'b1});
  endtask

  task automatic push_text(string s);
    for (int i = 0; i < s.len(); i++) push_byte(s[i]);
  endtask

  function automatic logic [7:0] hex_char(logic [3:0] nib);
    if (nib < 4'd10) return 8'("0" + nib);
    if ($urandom_range(1)) return 8'("a" + nib - 10);
    return 8'("A" + nib - 10);
  endfunction

  task automatic push_escape_u(logic [15:0] v);
    push_text("\\u");
    for (int i = 3; i >= 0; i--) push_byte(hex_char(v[i*4 +: 4]));
  endtask

  function automatic int span_value(int lo, int hi);
    case ($urandom_range(3))
      0: return lo;
      1: return hi;
      default: return $urandom_range(hi, lo);
    endcase
  endfunction

  function automatic logic [7:0] plain_byte();
    logic [7:0] b;
    do b = 8'($urandom_range(255, 32)); while (b == "\"" || b == "\\");
    return b;
  endfunction

  function automatic logic [7:0] non_hex_byte();
    logic [7:0] b;
    do b = 8'($urandom_range(255)); while (b inside {["0":"9"], ["a":"f"], ["A":"F"]});
    return b;
  endfunction

  function automatic logic [15:0] bmp_value();
    case ($urandom_range(3))
      0: return 16'(span_value('h0, 'h7f));
      1: return 16'(span_value('h80, 'h7ff));
      2: return 16'(span_value('h800, 'hd7ff));
      default: return 16'(span_value('he000, 'hffff));
    endcase
  endfunction

  // Mostly well-formed pieces of string body, the rest malformed on purpose.
  task automatic add_random_piece();
    int         pick;
    int         err_sel;
    string      escapes;
    logic [7:0] b;
    logic [15:0] v;
    escapes = "\"\\/bfnrt";
    pick = $urandom_range(99);
    if (pick < 40) begin
      repeat ($urandom_range(3, 1)) push_byte(plain_byte());
    end else if (pick < 52) begin
      push_byte("\\");
      push_byte(escapes[$urandom_range(7)]);
    end else if (pick < 63) begin
      push_escape_u(bmp_value());
    end else if (pick < 71) begin
      push_escape_u(16'(span_value('hd800, 'hdbff)));
      push_escape_u(16'(span_value('hdc00, 'hdfff)));
    end else if (pick < 77) begin
      push_byte("\"");
    end else begin
      err_sel = $urandom_range(9);
      case (err_sel)
        0: push_byte(8'($urandom_range(31)));
        1: push_eot();
        2: begin
          push_byte("\\");
          push_eot();
        end
        3: begin
          do b = 8'($urandom_range(255));
          while (b inside {"\"", "\\", "/", "b", "f", "n", "r", "t", "u"});
          push_byte("\\");
          push_byte(b);
        end
        4, 5: begin
          push_text("\\u");
          repeat ($urandom_range(3)) push_byte(hex_char(4'($urandom_range(15))));
          if (err_sel == 4) push_eot();
          else push_byte(non_hex_byte());
        end
        6: push_escape_u(16'(span_value('hdc00, 'hdfff)));
        7: begin
          push_escape_u(16'(span_value('hd800, 'hdbff)));
          case ($urandom_range(3))
            0: begin
              do b = 8'($urandom_range(255)); while (b == "\\");
              push_byte(b);
            end
            1: push_eot();
            2: begin
              push_byte("\\");
              do b = 8'($urandom_range(255)); while (b == "u");
              push_byte(b);
            end
            default: begin
              push_byte("\\");
              push_eot();
            end
          endcase
        end
        8: begin
          push_escape_u(16'(span_value('hd800, 'hdbff)));
          do v = 16'($urandom_range('hffff)); while (v >= 16'hdc00 && v <= 16'hdfff);
          push_escape_u(v);
        end
        default: begin
          push_escape_u(16'(span_value('hd800, 'hdbff)));
          push_text("\\u");
          repeat ($urandom_range(3)) push_byte(hex_char(4'($urandom_range(15))));
          if ($urandom_range(1)) push_eot();
          else push_byte(non_hex_byte());
        end
      endcase
    end
  endtask

  task automatic send_item(text_item_t it);
    @(negedge clk);
    while ($urandom_range(99) < idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= it.data;
    in_tuser  <= it.eot;
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic drain();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
  endtask

  initial begin
    int total;

    // Field extremes, the string end and one of each malformed case.
    push_byte(8'h00);
    push_byte(8'h1f);
    push_byte(8'h20);
    push_byte(8'hff);
    push_eot();
    push_byte("\\");
    push_eot();
    push_text("\\x");
    push_text("\\u12");
    push_eot();
    push_text("\\u0g");
    push_text("\\uDC00");
    push_text("\\uD800x");
    push_text("\\uDBFF\\uDFFF");
    push_text("\\uD800\\u0041");
    push_text("\\uFFFF");
    push_byte("\"");
    while (text_q.size() < TotalItems) add_random_piece();
    total = text_q.size();

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin
          idle_pct  = 0;
          stall_pct = 0;
        end
        1: begin
          idle_pct  = 73;
          stall_pct = 0;
        end
        2: begin
          idle_pct  = 0;
          stall_pct = 73;
        end
        default: begin
          idle_pct  = 33;
          stall_pct = 33;
        end
      endcase
      for (int i = ph * total / 4; i < (ph + 1) * total / 4; i++) send_item(text_q[i]);
      drain();
    end

    repeat (EndWait) @(negedge clk);
    if (mismatches == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

endmodule
